>>> sv/stwl_pkg.sv
// Package for the sliding time-window latency statistics block.
// Holds default parameters, controller states and the command/status structs.
// No dependencies.
package stwl_pkg;

  localparam int RING_DEPTH_DEF   = 1024;
  localparam int LATENCY_BITS_DEF = 16;
  localparam logic [30:0] WINDOW_RESET = 31'd30000;

  typedef enum logic [3:0] {
    S_IDLE, S_DROPF, S_APPEND, S_EVWAIT, S_EVCHK,
    S_MULA, S_MULB_LD, S_MULB, S_SQRT_LD, S_SQRT,
    S_DIVS_LD, S_DIVS, S_DIVM_LD, S_DIVM, S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic drop;
    logic append;
    logic ld_mula;
    logic ld_mulb;
    logic step_mul;
    logic ld_sqrt;
    logic step_sqrt;
    logic ld_divs;
    logic ld_divm;
    logic step_div;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic evict;
    logic last;
    logic out_free;
  } status_t;

endpackage

>>> sv/stwl_ctrl.sv
// Controller state machine for the latency statistics block.
// Depends on stwl_pkg; drives commands to stwl_dp and reads its status.
module stwl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stwl_pkg::status_t st,
  output stwl_pkg::cmd_t    cmd
);

  stwl_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= stwl_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stwl_pkg::S_IDLE:    if (in_valid) state_nxt = st.full ? stwl_pkg::S_DROPF
                                                             : stwl_pkg::S_APPEND;
      stwl_pkg::S_DROPF:   state_nxt = stwl_pkg::S_APPEND;
      stwl_pkg::S_APPEND:  state_nxt = stwl_pkg::S_EVWAIT;
      stwl_pkg::S_EVWAIT:  state_nxt = stwl_pkg::S_EVCHK;
      stwl_pkg::S_EVCHK:   state_nxt = st.evict ? stwl_pkg::S_EVWAIT : stwl_pkg::S_MULA;
      stwl_pkg::S_MULA:    if (st.last) state_nxt = stwl_pkg::S_MULB_LD;
      stwl_pkg::S_MULB_LD: state_nxt = stwl_pkg::S_MULB;
      stwl_pkg::S_MULB:    if (st.last) state_nxt = stwl_pkg::S_SQRT_LD;
      stwl_pkg::S_SQRT_LD: state_nxt = stwl_pkg::S_SQRT;
      stwl_pkg::S_SQRT:    if (st.last) state_nxt = stwl_pkg::S_DIVS_LD;
      stwl_pkg::S_DIVS_LD: state_nxt = stwl_pkg::S_DIVS;
      stwl_pkg::S_DIVS:    if (st.last) state_nxt = stwl_pkg::S_DIVM_LD;
      stwl_pkg::S_DIVM_LD: state_nxt = stwl_pkg::S_DIVM;
      stwl_pkg::S_DIVM:    if (st.last) state_nxt = stwl_pkg::S_DONE;
      stwl_pkg::S_DONE:    if (st.out_free) state_nxt = stwl_pkg::S_IDLE;
      default:             state_nxt = stwl_pkg::S_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      stwl_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      stwl_pkg::S_DROPF:   cmd.drop      = 1'b1;
      stwl_pkg::S_APPEND:  cmd.append    = 1'b1;
      stwl_pkg::S_EVWAIT:  ;
      stwl_pkg::S_EVCHK: begin
        cmd.drop    = st.evict;
        cmd.ld_mula = !st.evict;
      end
      stwl_pkg::S_MULA, stwl_pkg::S_MULB: cmd.step_mul = 1'b1;
      stwl_pkg::S_MULB_LD: cmd.ld_mulb   = 1'b1;
      stwl_pkg::S_SQRT_LD: cmd.ld_sqrt   = 1'b1;
      stwl_pkg::S_SQRT:    cmd.step_sqrt = 1'b1;
      stwl_pkg::S_DIVS_LD: cmd.ld_divs   = 1'b1;
      stwl_pkg::S_DIVM_LD: cmd.ld_divm   = 1'b1;
      stwl_pkg::S_DIVS, stwl_pkg::S_DIVM: cmd.step_div = 1'b1;
      stwl_pkg::S_DONE:    cmd.out_load  = st.out_free;
      default:             ;
    endcase
  end

endmodule

>>> sv/stwl_dp.sv
// Datapath: sample rings, running sums, serial multiplier, square root and divider.
// Depends on stwl_pkg; sequenced by stwl_ctrl.
module stwl_dp #(
  parameter int RING_DEPTH   = stwl_pkg::RING_DEPTH_DEF,
  parameter int LATENCY_BITS = stwl_pkg::LATENCY_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  stwl_pkg::cmd_t    cmd,
  output stwl_pkg::status_t st,
  input  logic              cfg_valid,
  input  logic [30:0]       cfg_window_ms,
  input  logic [31:0]       in_sample_time_ms,
  input  logic [15:0]       in_sample_latency_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [10:0]       out_sample_count,
  output logic [25:0]       out_latency_sum,
  output logic [19:0]       out_mean_q4,
  output logic [19:0]       out_stddev_q4,
  output logic              out_overflow
);

  localparam int L    = LATENCY_BITS;
  localparam int IW   = $clog2(RING_DEPTH);
  localparam int CW   = $clog2(RING_DEPTH + 1);
  localparam int SW   = L + CW;
  localparam int QW   = 2 * L + CW;
  localparam int VW   = QW + CW;
  localparam int DW   = VW + 8;
  localparam int RW   = DW / 2;
  localparam int PW   = QW + SW;
  localparam int CTRW = $clog2(RW + 1);

  // sample rings
  logic [31:0]   time_mem [RING_DEPTH];
  logic [L-1:0]  lat_mem  [RING_DEPTH];
  logic [31:0]   rd_time_r;
  logic [L-1:0]  rd_lat_r;

  logic [IW-1:0] oldest_r;
  logic [CW-1:0] count_r;
  logic [SW-1:0] sum_r;
  logic [QW-1:0] sq_r;
  logic [30:0]   window_r;
  logic [31:0]   t_r;
  logic [L-1:0]  lat_r;
  logic          ovf_r;

  logic [PW-1:0] mul_p_r;
  logic [QW-1:0] mul_x_r;
  logic [VW-1:0] a_r;
  logic [DW-1:0] rad_r;
  logic [RW-1:0] root_r;
  logic [RW+1:0] srem_r;
  logic [RW-1:0] dv_q_r;
  logic [CW-1:0] dv_rem_r;
  logic [19:0]   sd_r;
  logic [CTRW-1:0] ctr_r;
  logic          out_valid_r;

  logic [CW:0]   slot_sum;
  logic [IW-1:0] slot;
  logic [IW-1:0] oldest_inc;
  logic [QW:0]   mul_up;
  logic [VW-1:0] b_val;
  logic [RW+3:0] rem2, trial;
  logic [CW:0]   r2;
  logic          dv_ge;

  assign slot_sum   = (CW+1)'(oldest_r) + (CW+1)'(count_r);
  assign slot       = (slot_sum >= (CW+1)'(RING_DEPTH)) ?
                      IW'(slot_sum - (CW+1)'(RING_DEPTH)) : IW'(slot_sum);
  assign oldest_inc = (oldest_r == IW'(RING_DEPTH - 1)) ? '0 : oldest_r + 1'b1;

  // ring write and registered read of the oldest entry
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      time_mem[slot] <= t_r;
      lat_mem[slot]  <= lat_r;
    end
    rd_time_r <= time_mem[oldest_r];
    rd_lat_r  <= lat_mem[oldest_r];
  end

  // window register
  always_ff @(posedge clk) begin
    if (!rst_n)         window_r <= stwl_pkg::WINDOW_RESET;
    else if (cfg_valid) window_r <= cfg_window_ms;
  end

  // sample latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_r   <= in_sample_time_ms;
      lat_r <= L'(in_sample_latency_ms);
      ovf_r <= st.full;
    end
  end

  // ring pointers and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
      sum_r    <= '0;
      sq_r     <= '0;
    end else if (cmd.drop) begin
      oldest_r <= oldest_inc;
      count_r  <= count_r - 1'b1;
      sum_r    <= sum_r - SW'(rd_lat_r);
      sq_r     <= sq_r - QW'(rd_lat_r * rd_lat_r);
    end else if (cmd.append) begin
      count_r  <= count_r + 1'b1;
      sum_r    <= sum_r + SW'(lat_r);
      sq_r     <= sq_r + QW'(lat_r * lat_r);
    end
  end

  // shift-add multiplier, one multiplier bit per cycle
  assign mul_up = {1'b0, mul_p_r[PW-1:SW]} + (mul_p_r[0] ? {1'b0, mul_x_r} : '0);
  always_ff @(posedge clk) begin
    if (cmd.ld_mula) begin
      mul_x_r <= sq_r;
      mul_p_r <= {{QW{1'b0}}, SW'(count_r)};
    end else if (cmd.ld_mulb) begin
      a_r     <= VW'(mul_p_r);
      mul_x_r <= QW'(sum_r);
      mul_p_r <= {{QW{1'b0}}, sum_r};
    end else if (cmd.step_mul) begin
      mul_p_r <= {mul_up, mul_p_r[SW-1:1]};
    end
  end

  // digit-by-digit square root, one result bit per cycle
  assign b_val = VW'(mul_p_r);
  assign rem2  = {srem_r, rad_r[DW-1:DW-2]};
  assign trial = {2'b00, root_r, 2'b01};
  always_ff @(posedge clk) begin
    if (cmd.ld_sqrt) begin
      rad_r  <= (a_r >= b_val) ? {a_r - b_val, 8'h00} : '0;
      root_r <= '0;
      srem_r <= '0;
    end else if (cmd.step_sqrt) begin
      rad_r  <= rad_r << 2;
      if (rem2 >= trial) begin
        srem_r <= (RW+2)'(rem2 - trial);
        root_r <= {root_r[RW-2:0], 1'b1};
      end else begin
        srem_r <= (RW+2)'(rem2);
        root_r <= {root_r[RW-2:0], 1'b0};
      end
    end
  end

  // restoring divider by the sample count, one quotient bit per cycle
  assign r2    = {dv_rem_r, dv_q_r[RW-1]};
  assign dv_ge = r2 >= {1'b0, count_r};
  always_ff @(posedge clk) begin
    if (cmd.ld_divs) begin
      dv_q_r   <= root_r;
      dv_rem_r <= '0;
    end else if (cmd.ld_divm) begin
      sd_r     <= 20'(dv_q_r);
      dv_q_r   <= RW'({sum_r, 4'h0});
      dv_rem_r <= '0;
    end else if (cmd.step_div) begin
      dv_rem_r <= dv_ge ? CW'(r2 - {1'b0, count_r}) : CW'(r2);
      dv_q_r   <= {dv_q_r[RW-2:0], dv_ge};
    end
  end

  // iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n)                           ctr_r <= '0;
    else if (cmd.ld_mula || cmd.ld_mulb)  ctr_r <= CTRW'(SW - 1);
    else if (cmd.ld_sqrt || cmd.ld_divs || cmd.ld_divm) ctr_r <= CTRW'(RW - 1);
    else if ((cmd.step_mul || cmd.step_sqrt || cmd.step_div) && ctr_r != '0)
      ctr_r <= ctr_r - 1'b1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n)                      out_valid_r <= 1'b0;
    else if (cmd.out_load)           out_valid_r <= 1'b1;
    else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_count <= 11'(count_r);
      out_latency_sum  <= 26'(sum_r);
      out_mean_q4      <= 20'(dv_q_r);
      out_stddev_q4    <= sd_r;
      out_overflow     <= ovf_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign st.full     = (count_r == CW'(RING_DEPTH));
  assign st.evict    = (count_r != '0) && ((t_r - rd_time_r) > {1'b0, window_r});
  assign st.last     = (ctr_r == '0);
  assign st.out_free = !out_valid_r || !out_stall;

endmodule

>>> sv/sliding_time_window_latency_stats_top.sv
// Each input transaction yields a result once the oldest sample is dropped (if the ring is full),
// stale samples are evicted and the serial multiplier, square root and divider have run. One
// sample is handled at a time: in_stall stays high until the result is loaded, so result
// stalls also hold new input. Synchronous active-low reset clears the ring to empty, sums to
// zero, the window to 30000 ms; no clearing pass is needed.
module sliding_time_window_latency_stats_top #(
  parameter int RING_DEPTH   = stwl_pkg::RING_DEPTH_DEF,
  parameter int LATENCY_BITS = stwl_pkg::LATENCY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample_time_ms,
  input  logic [15:0] in_sample_latency_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_sample_count,
  output logic [25:0] out_latency_sum,
  output logic [19:0] out_mean_q4,
  output logic [19:0] out_stddev_q4,
  output logic        out_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_window_ms
);

  stwl_pkg::cmd_t    cmd;
  stwl_pkg::status_t st;

  assign cfg_ready = 1'b1;

  stwl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  stwl_dp #(
    .RING_DEPTH   (RING_DEPTH),
    .LATENCY_BITS (LATENCY_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .cfg_valid            (cfg_valid),
    .cfg_window_ms        (cfg_window_ms),
    .in_sample_time_ms    (in_sample_time_ms),
    .in_sample_latency_ms (in_sample_latency_ms),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_sample_count     (out_sample_count),
    .out_latency_sum      (out_latency_sum),
    .out_mean_q4          (out_mean_q4),
    .out_stddev_q4        (out_stddev_q4),
    .out_overflow         (out_overflow)
  );

endmodule

>>> sv/stwl_checker.sv
// Port-level checker for the latency statistics top level, attached by bind.
// Depends only on the top level's ports.
module stwl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [10:0] out_sample_count,
  input logic [25:0] out_latency_sum
);

  // a stalled result transaction holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_count)
                               && $stable(out_latency_sum))
    else $error("stalled result changed");

  // every result covers at least the new sample
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample_count != 11'd0)
    else $error("result with zero count");

  // one sample in flight: busy right after an accepted transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second sample accepted while busy");

  // reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sliding_time_window_latency_stats_top stwl_checker u_stwl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sample_count (out_sample_count),
  .out_latency_sum  (out_latency_sum)
);

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench for sliding_time_window_latency_stats_top: directed table, then random phases
// under several window settings, checked against typed rows or an in-bench statistics predictor.
// Depends on stwl_pkg and the top-level RTL.
module tb;

  localparam int DEPTH      = stwl_pkg::RING_DEPTH_DEF;
  localparam int WDOG_MAX   = 20000;
  localparam int DRAIN_CYC  = 300;
  localparam int PEND_DEPTH = 8;

  typedef struct {
    logic [10:0] cnt;
    logic [25:0] sum;
    logic [19:0] mean;
    logic [19:0] sd;
    logic        ovf;
  } stats_t;

  typedef struct {
    logic [31:0] t;
    logic [15:0] lat;
    bit          typed;
    stats_t      want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_sample_time_ms;
  logic [15:0] in_sample_latency_ms;
  logic        out_valid;
  logic        out_stall;
  logic [10:0] out_sample_count;
  logic [25:0] out_latency_sum;
  logic [19:0] out_mean_q4;
  logic [19:0] out_stddev_q4;
  logic        out_overflow;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [30:0] cfg_window_ms;

  sliding_time_window_latency_stats_top dut (.*);

  // Predictor state: a shadow of the sample ring and the running sums
  logic [31:0] time_hist [DEPTH];
  logic [15:0] lat_hist  [DEPTH];
  int unsigned head, held;
  longint unsigned lat_total, sq_total;
  logic [30:0] window_cur;

  // Expected results in send order; write and read counts index a small ring
  stats_t pending_stats [PEND_DEPTH];
  int     pend_wr, pend_rd;
  int     err_cnt;
  int     idle_cnt;
  logic [31:0] now_ms;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    logic [63:0]  r, c;
    logic [127:0] p;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      p = {64'd0, c} * {64'd0, c};
      if (p <= {64'd0, v}) r = c;
    end
    return r;
  endfunction

  function automatic void drop_oldest_sample();
    longint unsigned l;
    l = lat_hist[head];
    lat_total -= l;
    sq_total  -= l * l;
    head = (head + 1) % DEPTH;
    held--;
  endfunction

  // Apply one sample to the shadow state and compute its statistics
  function automatic stats_t window_stats(logic [31:0] t, logic [15:0] lat);
    stats_t s;
    longint unsigned n, a, b, d, l;
    logic [31:0] age;
    s.ovf = 0;
    if (held >= DEPTH) begin
      drop_oldest_sample();
      s.ovf = 1;
    end
    time_hist[(head + held) % DEPTH] = t;
    lat_hist[(head + held) % DEPTH]  = lat;
    held++;
    l = lat;
    lat_total += l;
    sq_total  += l * l;
    while (held > 0) begin
      age = t - time_hist[head];
      if (age <= {1'b0, window_cur}) break;
      drop_oldest_sample();
    end
    n = held;
    a = n * sq_total;
    b = lat_total * lat_total;
    d = (b <= a) ? (a - b) << 8 : 0;
    s.cnt  = n[10:0];
    s.sum  = lat_total[25:0];
    s.mean = 20'((lat_total * 16) / n);
    s.sd   = (b <= a) ? 20'(root_floor(d) / n) : 20'd0;
    return s;
  endfunction

  // Send one transaction and hold it until accepted
  task automatic send_sample(logic [31:0] t, logic [15:0] lat, bit typed, stats_t want);
    stats_t s;
    in_valid             <= 1'b1;
    in_sample_time_ms    <= t;
    in_sample_latency_ms <= lat;
    s = window_stats(t, lat);
    pending_stats[pend_wr % PEND_DEPTH] = typed ? want : s;
    pend_wr++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic sender_gap();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 50) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else if (r < 98) n = $urandom_range(4, 20);
    else n = $urandom_range(40, 120);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Wait for every result, let the block settle, then write the window
  task automatic set_window(logic [30:0] w);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_window_ms <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    window_cur = w;
  endtask

  function automatic logic [15:0] pick_latency();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r < 6) return 16'($urandom_range(0, 255));
    return 16'($urandom);
  endfunction

  // Mostly steady time steps, a few random jumps anywhere in the 32-bit range
  task automatic run_phase(logic [30:0] w, int items, int step_max, int noise_pct);
    set_window(w);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < noise_pct) now_ms = $urandom;
      else now_ms = now_ms + $urandom_range(0, step_max);
      send_sample(now_ms, pick_latency(), 0, '{default: 0});
      sender_gap();
    end
  endtask

  // Receiver back-pressure: mostly free, short bursts, rare long stalls
  initial begin
    int left, r;
    out_stall = 1'b0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left > 0) begin
        left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else if (r < 97) begin
          out_stall <= 1'b1;
          left = $urandom_range(0, 4);
        end else begin
          out_stall <= 1'b1;
          left = $urandom_range(30, 100);
        end
      end
    end
  end

  // Result checker and watchdog
  always @(posedge clk) begin
    stats_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cnt <= 0;
      else
        idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WDOG_MAX) begin
        $display("sliding_time_window_latency_stats_top verification failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pend_wr == pend_rd) begin
          $error("unexpected result transaction");
          err_cnt++;
        end else begin
          e = pending_stats[pend_rd % PEND_DEPTH];
          pend_rd++;
          if (out_sample_count !== e.cnt) begin
            $error("sample_count: expected %0d, got %0d", e.cnt, out_sample_count);
            err_cnt++;
          end
          if (out_latency_sum !== e.sum) begin
            $error("latency_sum: expected %0d, got %0d", e.sum, out_latency_sum);
            err_cnt++;
          end
          if (out_mean_q4 !== e.mean) begin
            $error("mean_q4: expected %0d, got %0d", e.mean, out_mean_q4);
            err_cnt++;
          end
          if (out_stddev_q4 !== e.sd) begin
            $error("stddev_q4: expected %0d, got %0d", e.sd, out_stddev_q4);
            err_cnt++;
          end
          if (out_overflow !== e.ovf) begin
            $error("overflow: expected %0d, got %0d", e.ovf, out_overflow);
            err_cnt++;
          end
        end
      end
    end
  end

  // Directed rows: reset values, extremes, eviction, time wrap, time going backward
  row_t directed [10] = '{
    '{32'd0,          16'hFFFF, 1, '{11'd1, 26'd65535, 20'd1048560, 20'd0,      1'b0}},
    '{32'd0,          16'd0,    1, '{11'd2, 26'd65535, 20'd524280,  20'd524280, 1'b0}},
    '{32'd30001,      16'd0,    1, '{11'd1, 26'd0,     20'd0,       20'd0,      1'b0}},
    '{32'd60001,      16'd5,    1, '{11'd2, 26'd5,     20'd40,      20'd40,     1'b0}},
    '{32'd75001,      16'd1,    0, '{default: 0}},
    '{32'hFFFF_FFF0,  16'hFFFF, 1, '{11'd1, 26'd65535, 20'd1048560, 20'd0,      1'b0}},
    '{32'h0000_0010,  16'd100,  0, '{default: 0}},
    '{32'd5,          16'd7,    0, '{default: 0}},
    '{32'h7FFF_FFFF,  16'h5555, 0, '{default: 0}},
    '{32'h8000_0000,  16'hAAAA, 0, '{default: 0}}
  };

  initial begin
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_sample_time_ms    = '0;
    in_sample_latency_ms = '0;
    cfg_valid            = 1'b0;
    cfg_window_ms        = '0;
    err_cnt              = 0;
    idle_cnt             = 0;
    pend_wr              = 0;
    pend_rd              = 0;
    head = 0; held = 0; lat_total = 0; sq_total = 0;
    window_cur = stwl_pkg::WINDOW_RESET;
    now_ms = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_sample(directed[i].t, directed[i].lat, directed[i].typed, directed[i].want);
      sender_gap();
    end

    // Window 0: only same-time samples survive together
    now_ms = $urandom;
    run_phase(31'd0, 150, 2, 5);
    // Widest window with slow time: fills the ring and forces overflow
    run_phase(31'h7FFF_FFFF, 1200, 3, 0);
    run_phase(31'd30000, 250, 400, 5);
    run_phase(31'd50, 200, 20, 5);
    // Near the wrap point of the 32-bit clock
    now_ms = 32'hFFFF_F000;
    run_phase(31'd1000, 150, 60, 3);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0 && pend_wr == pend_rd)
      $display("sliding_time_window_latency_stats_top verification clean");
    else
      $display("sliding_time_window_latency_stats_top verification failed");
    $finish;
  end

endmodule
